FILE: sv/aesc_pkg.sv
// aesc_pkg: widths, reset values, register indexes, sequencer states and the
// saturation helper for the accelerometer ema / scale / calibrate block.
// no dependencies; imported by accel_ema_scale_calibrate and aesc_checker.
package aesc_pkg;

   localparam int ADC_BITS         = 10;
   localparam int FILTER_FRAC_BITS = 8;
   localparam int FILT_BITS        = ADC_BITS + FILTER_FRAC_BITS;
   localparam int ALPHA_BITS       = 9;
   localparam int ALPHA_SHIFT      = 8;
   localparam int ALPHA_ONE        = 2 ** ALPHA_SHIFT;
   localparam int GAIN_BITS        = 16;
   localparam int ACC_BITS         = 16;
   localparam int COUNT_BITS       = 8;
   localparam int NUM_AXES         = 3;
   localparam int AXIS_BITS        = 2;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = (FILT_BITS > GAIN_BITS) ? FILT_BITS : GAIN_BITS;

   localparam int DIFF_BITS   = FILT_BITS + 1;
   localparam int MULB_BITS   = GAIN_BITS + 1;
   localparam int PROD_BITS   = DIFF_BITS + MULB_BITS;
   localparam int SCALE_SHIFT = 16;
   localparam int SCALED_BITS = PROD_BITS - SCALE_SHIFT;
   localparam int SAT_BITS    = (SCALED_BITS > ACC_BITS + 1) ? SCALED_BITS : ACC_BITS + 1;

   localparam int ACC_MAX = 2 ** (ACC_BITS - 1) - 1;
   localparam int ACC_MIN = -(2 ** (ACC_BITS - 1));

   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(26);
   localparam logic [FILT_BITS-1:0]  ZERO_RESET  = FILT_BITS'(128000);
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = GAIN_BITS'(10240);
   localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(100);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_ALPHA = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_LEVEL_X = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_LEVEL_Y = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_LEVEL_Z = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_GAIN_X = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_GAIN_Y = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_GAIN_Z = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CALIB_LIMIT  = 3'd7;

   localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

   typedef logic signed [ACC_BITS-1:0] accel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT,
      ST_UPD,
      ST_SCALE,
      ST_LAST,
      ST_FINAL
   } state_type;

   function automatic accel_type sat_acc(input logic signed [SAT_BITS-1:0] v);
      logic signed [SAT_BITS-1:0] hi;
      logic signed [SAT_BITS-1:0] lo;
      hi = SAT_BITS'(ACC_MAX);
      lo = SAT_BITS'(ACC_MIN);
      if (v > hi) begin
         sat_acc = hi[ACC_BITS-1:0];
      end else if (v < lo) begin
         sat_acc = lo[ACC_BITS-1:0];
      end else begin
         sat_acc = v[ACC_BITS-1:0];
      end
   endfunction

endpackage

FILE: sv/accel_ema_scale_calibrate.sv
// accel_ema_scale_calibrate: per-axis ema filter, scaling to q4.12 g and
// start-up offset calibration on one shared 19x17 signed multiplier.
// depends on aesc_pkg.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   request | req_cmd, req_raw_x/y/z                  | req_valid / req_stall
//   result  | rsp_accel_x/y/z, rsp_ready_res          | rsp_valid / rsp_stall
//   csr     | csr_index, csr_wdata                    | csr_valid / csr_ready
//
// a sample beat uses the multiplier six times (filter and gain per axis)
// in filt, upd, scale per axis, then last and final; a restart beat goes
// to final. req_stall is high until the sequencer is back in idle.
// the result sits in an output register; a stalled result holds the last
// sequencer step until it drains. reset is synchronous; filters, offsets
// and count clear, calibration restarts, registers return to defaults.
module accel_ema_scale_calibrate
   import aesc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [ADC_BITS-1:0]       req_raw_x,
   input  logic [ADC_BITS-1:0]       req_raw_y,
   input  logic [ADC_BITS-1:0]       req_raw_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output accel_type                 rsp_accel_x,
   output accel_type                 rsp_accel_y,
   output accel_type                 rsp_accel_z,
   output logic                      rsp_ready_res,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   state_type                      state_ff, state_in;
   logic [AXIS_BITS-1:0]           axis_ff, axis_in;
   logic                           cmd_ff, cmd_in;
   logic [ADC_BITS-1:0]            raw_ff [NUM_AXES];
   logic [ADC_BITS-1:0]            raw_in [NUM_AXES];
   logic [FILT_BITS-1:0]           filt_ff [NUM_AXES];
   logic [FILT_BITS-1:0]           filt_in [NUM_AXES];
   logic signed [PROD_BITS-1:0]    prod_ff, prod_in;
   accel_type                      acc_ff [NUM_AXES];
   accel_type                      acc_in [NUM_AXES];
   accel_type                      offset_ff [NUM_AXES];
   accel_type                      offset_in [NUM_AXES];
   logic [COUNT_BITS-1:0]          count_ff, count_in;
   logic                           in_cal_ff, in_cal_in;

   logic [ALPHA_BITS-1:0]          alpha_ff, alpha_in;
   logic [FILT_BITS-1:0]           zero_ff [NUM_AXES];
   logic [FILT_BITS-1:0]           zero_in [NUM_AXES];
   logic [GAIN_BITS-1:0]           gain_ff [NUM_AXES];
   logic [GAIN_BITS-1:0]           gain_in [NUM_AXES];
   logic [COUNT_BITS-1:0]          limit_ff, limit_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   accel_type                      rsp_acc_ff [NUM_AXES];
   accel_type                      rsp_acc_in [NUM_AXES];
   logic                           rsp_ready_ff, rsp_ready_in;

   logic [ALPHA_BITS-1:0]          alpha_eff;
   logic [FILT_BITS-1:0]           filt_sel;
   logic [DIFF_BITS-1:0]           raw_ext;
   logic signed [DIFF_BITS-1:0]    mul_a;
   logic signed [MULB_BITS-1:0]    mul_b;
   logic signed [PROD_BITS-1:0]    prod;
   logic [FILT_BITS-1:0]           filt_upd;
   accel_type                      scaled_sat;
   logic [AXIS_BITS-1:0]           axis_prev;
   logic [COUNT_BITS-1:0]          count_inc;
   logic                           out_free;

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accel_x   = rsp_acc_ff[AXIS_X];
   assign rsp_accel_y   = rsp_acc_ff[AXIS_Y];
   assign rsp_accel_z   = rsp_acc_ff[AXIS_Z];
   assign rsp_ready_res = rsp_ready_ff;

   // shared datapath
   assign alpha_eff = (alpha_ff > ALPHA_BITS'(ALPHA_ONE)) ? ALPHA_BITS'(ALPHA_ONE) : alpha_ff;
   assign filt_sel  = filt_ff[axis_ff];
   assign raw_ext   = {1'b0, raw_ff[axis_ff], FILTER_FRAC_BITS'(0)};
   assign axis_prev = axis_ff - AXIS_BITS'(1);

   always_comb begin
      if (state_ff == ST_SCALE) begin
         mul_a = $signed({1'b0, filt_sel} - {1'b0, zero_ff[axis_ff]});
         mul_b = $signed({1'b0, gain_ff[axis_ff]});
      end else begin
         mul_a = $signed(raw_ext - {1'b0, filt_sel});
         mul_b = $signed(MULB_BITS'(alpha_eff));
      end
   end

   assign prod       = mul_a * mul_b;
   assign filt_upd   = filt_sel + prod_ff[ALPHA_SHIFT +: FILT_BITS];
   assign scaled_sat = sat_acc(SAT_BITS'($signed(prod_ff[PROD_BITS-1:SCALE_SHIFT])));
   assign count_inc  = (count_ff != '1) ? count_ff + COUNT_BITS'(1) : count_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cmd_in       = cmd_ff;
      raw_in       = raw_ff;
      filt_in      = filt_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      offset_in    = offset_ff;
      count_in     = count_ff;
      in_cal_in    = in_cal_ff;
      alpha_in     = alpha_ff;
      zero_in      = zero_ff;
      gain_in      = gain_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_acc_in   = rsp_acc_ff;
      rsp_ready_in = rsp_ready_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_FILTER_ALPHA: alpha_in        = csr_wdata[ALPHA_BITS-1:0];
            CSR_ZERO_LEVEL_X: zero_in[AXIS_X] = csr_wdata[FILT_BITS-1:0];
            CSR_ZERO_LEVEL_Y: zero_in[AXIS_Y] = csr_wdata[FILT_BITS-1:0];
            CSR_ZERO_LEVEL_Z: zero_in[AXIS_Z] = csr_wdata[FILT_BITS-1:0];
            CSR_SCALE_GAIN_X: gain_in[AXIS_X] = csr_wdata[GAIN_BITS-1:0];
            CSR_SCALE_GAIN_Y: gain_in[AXIS_Y] = csr_wdata[GAIN_BITS-1:0];
            CSR_SCALE_GAIN_Z: gain_in[AXIS_Z] = csr_wdata[GAIN_BITS-1:0];
            CSR_CALIB_LIMIT:  limit_in        = csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_cmd;
               raw_in[AXIS_X] = req_raw_x;
               raw_in[AXIS_Y] = req_raw_y;
               raw_in[AXIS_Z] = req_raw_z;
               axis_in        = AXIS_X;
               state_in       = req_cmd ? ST_FINAL : ST_FILT;
            end
         end
         ST_FILT: begin
            prod_in = prod;
            if (axis_ff != AXIS_X) begin
               acc_in[axis_prev] = scaled_sat;
            end
            state_in = ST_UPD;
         end
         ST_UPD: begin
            filt_in[axis_ff] = filt_upd;
            state_in         = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in = prod;
            if (axis_ff == AXIS_Z) begin
               state_in = ST_LAST;
            end else begin
               axis_in  = axis_ff + AXIS_BITS'(1);
               state_in = ST_FILT;
            end
         end
         ST_LAST: begin
            acc_in[axis_ff] = scaled_sat;
            state_in        = ST_FINAL;
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (cmd_ff) begin
                  for (int k = 0; k < NUM_AXES; k++) begin
                     filt_in[k]    = '0;
                     rsp_acc_in[k] = '0;
                  end
                  count_in     = '0;
                  in_cal_in    = 1'b1;
                  rsp_ready_in = 1'b0;
               end else if (in_cal_ff) begin
                  count_in = count_inc;
                  if (count_inc > limit_ff) begin
                     offset_in = acc_ff;
                     in_cal_in = 1'b0;
                  end
                  rsp_acc_in   = acc_ff;
                  rsp_ready_in = 1'b0;
               end else begin
                  for (int k = 0; k < NUM_AXES; k++) begin
                     rsp_acc_in[k] = sat_acc(SAT_BITS'(acc_ff[k]) - SAT_BITS'(offset_ff[k]));
                  end
                  rsp_ready_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         in_cal_ff    <= 1'b1;
         alpha_ff     <= ALPHA_RESET;
         limit_ff     <= LIMIT_RESET;
         for (int k = 0; k < NUM_AXES; k++) begin
            filt_ff[k]   <= '0;
            offset_ff[k] <= '0;
            zero_ff[k]   <= ZERO_RESET;
            gain_ff[k]   <= GAIN_RESET;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         in_cal_ff    <= in_cal_in;
         alpha_ff     <= alpha_in;
         limit_ff     <= limit_in;
         filt_ff      <= filt_in;
         offset_ff    <= offset_in;
         zero_ff      <= zero_in;
         gain_ff      <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff      <= axis_in;
      cmd_ff       <= cmd_in;
      raw_ff       <= raw_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_ready_ff <= rsp_ready_in;
   end

endmodule

FILE: sv/aesc_checker.sv
// aesc_checker: port-level assertions for accel_ema_scale_calibrate,
// attached by the bind at the end of this file. depends on aesc_pkg.
module aesc_checker
   import aesc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_cmd,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input accel_type                 rsp_accel_x,
   input accel_type                 rsp_accel_y,
   input accel_type                 rsp_accel_z,
   input logic                      rsp_ready_res
);

   // no result beat survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a sample beat keeps the sequencer busy
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_cmd) |=> req_stall ##1 req_stall)
      else $error("request taken again during sample processing");

   // restart with a free output gives an all-zero uncalibrated beat
   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd && !rsp_valid) |=> ##1
         (rsp_valid && rsp_accel_x == 0 && rsp_accel_y == 0 && rsp_accel_z == 0
          && !rsp_ready_res))
      else $error("restart beat not zero");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_accel_x)
         && $stable(rsp_accel_y) && $stable(rsp_accel_z) && $stable(rsp_ready_res)))
      else $error("stalled result beat changed");

endmodule

bind accel_ema_scale_calibrate aesc_checker u_aesc_checker (.*);
